>>> hdl/tcw_pkg.sv
// Text console writer: shared types, command codes and character constants.
// Used by every module of the block but tcw_ram; depends on nothing else.
`default_nettype none

package tcw_pkg;

   // Wide enough for any cell index or count up to the largest supported buffer.
   localparam int IDX_W = 17;

   localparam int TAB_STEP = 8;

   localparam logic [2:0] CMD_PRINT      = 3'd0;
   localparam logic [2:0] CMD_PRINT_AT   = 3'd1;
   localparam logic [2:0] CMD_SET_CURSOR = 3'd2;
   localparam logic [2:0] CMD_CLEAR      = 3'd3;
   localparam logic [2:0] CMD_READ       = 3'd4;

   localparam logic [0:0] CSR_COLUMNS = 1'b0;
   localparam logic [0:0] CSR_LINES   = 1'b1;

   localparam logic [7:0] CHR_NL    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_BS    = 8'h08;
   localparam logic [7:0] CHR_BLANK = 8'h20;

   localparam logic [15:0] RESET_CELL    = 16'h0720;
   localparam logic [7:0]  RESET_COLOR   = 8'h07;
   localparam logic [7:0]  RESET_COLUMNS = 8'd80;
   localparam logic [5:0]  RESET_LINES   = 6'd25;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  character;
      logic [7:0]  attribute;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [11:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [11:0] cursor_offset;
      logic [15:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic [7:0]       cols;
      logic [5:0]       lines;
      logic [IDX_W-1:0] area;
   } geom_type;

endpackage

`default_nettype wire

>>> hdl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/tcw_geom.sv
// Configuration registers and effective screen geometry (columns, lines, area).
// Depends on tcw_pkg.
`default_nettype none

module tcw_geom #(
   parameter int MAX_CELLS = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_index,
   input  wire logic [7:0]       csr_wdata,
   output tcw_pkg::geom_type     geom
);

   import tcw_pkg::*;

   localparam logic [IDX_W-1:0] MAX_LIM = IDX_W'(MAX_CELLS);

   logic [7:0]       columns_ff, columns_in;
   logic [5:0]       lines_ff, lines_in;
   logic             recalc_ff, recalc_in;
   logic             check_ff, check_in;
   logic [7:0]       eff_cols_ff, eff_cols_in;
   logic [5:0]       eff_lines_ff, eff_lines_in;
   logic [IDX_W-1:0] area_ff, area_in;

   logic [7:0]       cols_nz, cols_lim;
   logic [5:0]       lines_nz;
   logic [IDX_W-1:0] prod;

   assign cols_nz  = (columns_ff == 8'd0) ? 8'd1 : columns_ff;
   assign cols_lim = (IDX_W'(cols_nz) > MAX_LIM) ? MAX_LIM[7:0] : cols_nz;
   assign lines_nz = (lines_ff == 6'd0) ? 6'd1 : lines_ff;
   assign prod     = IDX_W'(eff_cols_ff) * IDX_W'(eff_lines_ff);

   // The line count steps down until the screen fits in the buffer, which lands on
   // the largest count whose area does not exceed the capacity.
   always_comb begin
      columns_in   = columns_ff;
      lines_in     = lines_ff;
      recalc_in    = recalc_ff;
      check_in     = check_ff;
      eff_cols_in  = eff_cols_ff;
      eff_lines_in = eff_lines_ff;
      area_in      = area_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_LINES:   lines_in   = csr_wdata[5:0];
            default:     columns_in = columns_ff;
         endcase
         recalc_in = 1'b1;
         check_in  = 1'b0;
      end else if (recalc_ff) begin
         eff_cols_in  = cols_lim;
         eff_lines_in = lines_nz;
         recalc_in    = 1'b0;
         check_in     = 1'b1;
      end else if (check_ff) begin
         if (prod > MAX_LIM) begin
            eff_lines_in = eff_lines_ff - 6'd1;
         end else begin
            area_in  = prod;
            check_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= RESET_COLUMNS;
         lines_ff     <= RESET_LINES;
         recalc_ff    <= 1'b1;
         check_ff     <= 1'b0;
         eff_cols_ff  <= 8'd1;
         eff_lines_ff <= 6'd1;
         area_ff      <= IDX_W'(1);
      end else begin
         columns_ff   <= columns_in;
         lines_ff     <= lines_in;
         recalc_ff    <= recalc_in;
         check_ff     <= check_in;
         eff_cols_ff  <= eff_cols_in;
         eff_lines_ff <= eff_lines_in;
         area_ff      <= area_in;
      end
   end

   assign geom.busy  = csr_we | recalc_ff | check_ff;
   assign geom.cols  = eff_cols_ff;
   assign geom.lines = eff_lines_ff;
   assign geom.area  = area_ff;

endmodule

`default_nettype wire

>>> hdl/tcw_ctrl.sv
// Command sequencer: cursor, colour, character writes, scroll copy, fills and reads
// of the cell memory. Depends on tcw_pkg; drives the ports of one tcw_ram.
`default_nettype none

module tcw_ctrl #(
   parameter int MAX_CELLS = 4096,
   localparam int AW = $clog2(MAX_CELLS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire tcw_pkg::req_type  req_data,
   output logic                   req_stall,
   input  wire tcw_pkg::geom_type geom,
   input  wire logic              out_free,
   output logic                   done,
   output tcw_pkg::rsp_type       rsp_next,
   output logic                   mem_we,
   output logic [AW-1:0]          mem_waddr,
   output logic [15:0]            mem_wdata,
   output logic                   mem_re,
   output logic [AW-1:0]          mem_raddr,
   input  wire logic [15:0]       mem_rdata
);

   import tcw_pkg::*;

   localparam logic [IDX_W-1:0] MAX_LIM = IDX_W'(MAX_CELLS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PRINT  = 4'd1;
   localparam logic [3:0] ST_PWRITE = 4'd2;
   localparam logic [3:0] ST_NORM1  = 4'd3;
   localparam logic [3:0] ST_NORM2  = 4'd4;
   localparam logic [3:0] ST_SCROLL = 4'd5;
   localparam logic [3:0] ST_COPY   = 4'd6;
   localparam logic [3:0] ST_FILL   = 4'd7;
   localparam logic [3:0] ST_READ1  = 4'd8;
   localparam logic [3:0] ST_READ2  = 4'd9;
   localparam logic [3:0] ST_FIN1   = 4'd10;
   localparam logic [3:0] ST_FIN2   = 4'd11;

   localparam logic [1:0] RET_IDLE = 2'd0;
   localparam logic [1:0] RET_FIN  = 2'd1;
   localparam logic [1:0] RET_NORM = 2'd2;

   logic [3:0]       state_ff, state_in;
   logic             print_pend_ff, print_pend_in;
   logic [7:0]       ch_ff, ch_in;
   logic [7:0]       attr_ff, attr_in;
   logic [11:0]      cidx_ff, cidx_in;
   logic [8:0]       x_ff, x_in;
   logic [8:0]       y_ff, y_in;
   logic [7:0]       cur_col_ff, cur_col_in;
   logic [5:0]       cur_row_ff, cur_row_in;
   logic [7:0]       color_ff, color_in;
   logic [8:0]       k_ff, k_in;
   logic [IDX_W-1:0] prod_ff, prod_in;
   logic [8:0]       wx_ff, wx_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [15:0]      wword_ff, wword_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic [IDX_W-1:0] pdst_ff, pdst_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] fill_end_ff, fill_end_in;
   logic [15:0]      fill_word_ff, fill_word_in;
   logic [1:0]       ret_ff, ret_in;
   logic [15:0]      value_ff, value_in;

   logic [7:0]       attr_eff;
   logic [8:0]       lines9;
   logic [3:0]       after_norm;
   logic [IDX_W-1:0] widx;
   logic [IDX_W-1:0] cidx_ext;
   logic [IDX_W-1:0] offset_sum;

   assign req_stall  = (state_ff != ST_IDLE) || geom.busy;
   assign attr_eff   = (req_data.attribute == 8'd0) ? color_ff : req_data.attribute;
   assign lines9     = 9'(geom.lines);
   assign after_norm = print_pend_ff ? ST_PRINT : ST_FIN1;
   assign widx       = prod_ff + IDX_W'(wx_ff);
   assign cidx_ext   = IDX_W'(cidx_ff);
   assign offset_sum = prod_ff + IDX_W'(cur_col_ff);

   always_comb begin
      state_in      = state_ff;
      print_pend_in = print_pend_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      cidx_in       = cidx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      color_in      = color_ff;
      k_in          = k_ff;
      prod_in       = prod_ff;
      wx_in         = wx_ff;
      wr_pend_in    = wr_pend_ff;
      wword_in      = wword_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      pdst_in       = pdst_ff;
      pend_in       = pend_ff;
      fill_end_in   = fill_end_ff;
      fill_word_in  = fill_word_ff;
      ret_in        = ret_ff;
      value_in      = value_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      done          = 1'b0;
      rsp_next.cursor_offset = offset_sum[11:0];
      rsp_next.cell_value    = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               ch_in         = req_data.character;
               attr_in       = attr_eff;
               cidx_in       = req_data.cell_index;
               value_in      = 16'd0;
               print_pend_in = 1'b0;
               case (req_data.command)
                  CMD_PRINT: begin
                     x_in     = 9'(cur_col_ff);
                     y_in     = 9'(cur_row_ff);
                     state_in = ST_PRINT;
                  end
                  CMD_PRINT_AT: begin
                     x_in          = 9'(req_data.col);
                     y_in          = 9'(req_data.row);
                     print_pend_in = 1'b1;
                     state_in      = ST_NORM1;
                  end
                  CMD_SET_CURSOR: begin
                     x_in     = 9'(req_data.col);
                     y_in     = 9'(req_data.row);
                     state_in = ST_NORM1;
                  end
                  CMD_CLEAR: begin
                     color_in     = attr_eff;
                     cur_col_in   = 8'd0;
                     cur_row_in   = 6'd0;
                     dst_in       = '0;
                     fill_end_in  = geom.area;
                     fill_word_in = {attr_eff, CHR_BLANK};
                     ret_in       = RET_FIN;
                     state_in     = ST_FILL;
                  end
                  CMD_READ: begin
                     state_in = ST_READ1;
                  end
                  default: begin
                     state_in = ST_FIN1;
                  end
               endcase
            end
         end

         ST_PRINT: begin
            print_pend_in = 1'b0;
            wx_in         = x_ff;
            wr_pend_in    = 1'b0;
            wword_in      = {attr_ff, ch_ff};
            prod_in       = IDX_W'(y_ff) * IDX_W'(geom.cols);
            if (ch_ff == CHR_NL) begin
               x_in = 9'd0;
               y_in = y_ff + 9'd1;
            end else if (ch_ff == CHR_CR) begin
               x_in = 9'd0;
            end else if (ch_ff == CHR_TAB) begin
               x_in = (x_ff + 9'(TAB_STEP)) & ~9'(TAB_STEP - 1);
            end else if (ch_ff == CHR_BS) begin
               // Backspace blanks the cell it lands on, or the first cell of the line.
               if (x_ff != 9'd0) begin
                  x_in  = x_ff - 9'd1;
                  wx_in = x_ff - 9'd1;
               end
               wr_pend_in = 1'b1;
               wword_in   = {attr_ff, CHR_BLANK};
            end else if (ch_ff >= CHR_BLANK && !ch_ff[7]) begin
               wr_pend_in = 1'b1;
               x_in       = x_ff + 9'd1;
            end
            state_in = ST_PWRITE;
         end

         ST_PWRITE: begin
            // A cursor left stale by a geometry change may point outside the buffer.
            if (wr_pend_ff && (widx < MAX_LIM)) begin
               mem_we    = 1'b1;
               mem_waddr = widx[AW-1:0];
               mem_wdata = wword_ff;
            end
            state_in = ST_NORM1;
         end

         ST_NORM1: begin
            if (x_ff >= 9'(geom.cols)) begin
               x_in = 9'd0;
               y_in = y_ff + 9'd1;
            end
            state_in = ST_NORM2;
         end

         ST_NORM2: begin
            cur_col_in = x_ff[7:0];
            if (y_ff >= lines9) begin
               k_in       = y_ff - lines9 + 9'd1;
               y_in       = lines9 - 9'd1;
               cur_row_in = geom.lines - 6'd1;
               state_in   = ST_SCROLL;
            end else begin
               cur_row_in = y_ff[5:0];
               state_in   = after_norm;
            end
         end

         ST_SCROLL: begin
            // Copy starts k lines down; scrolling a whole screen or more copies nothing.
            if (k_ff < lines9) begin
               src_in = IDX_W'(k_ff) * IDX_W'(geom.cols);
            end else begin
               src_in = geom.area;
            end
            dst_in       = '0;
            pend_in      = 1'b0;
            fill_end_in  = geom.area;
            fill_word_in = {color_ff, CHR_BLANK};
            ret_in       = RET_NORM;
            state_in     = ST_COPY;
         end

         ST_COPY: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pdst_ff[AW-1:0];
               mem_wdata = mem_rdata;
            end
            if (src_ff < fill_end_ff) begin
               mem_re    = 1'b1;
               mem_raddr = src_ff[AW-1:0];
               pdst_in   = dst_ff;
               pend_in   = 1'b1;
               src_in    = src_ff + IDX_W'(1);
               dst_in    = dst_ff + IDX_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            if (dst_ff < fill_end_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff[AW-1:0];
               mem_wdata = fill_word_ff;
               dst_in    = dst_ff + IDX_W'(1);
            end else begin
               case (ret_ff)
                  RET_FIN:  state_in = ST_FIN1;
                  RET_NORM: state_in = after_norm;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end

         ST_READ1: begin
            if (cidx_ext < MAX_LIM) begin
               mem_re    = 1'b1;
               mem_raddr = cidx_ext[AW-1:0];
               state_in  = ST_READ2;
            end else begin
               state_in = ST_FIN1;
            end
         end

         ST_READ2: begin
            value_in = mem_rdata;
            state_in = ST_FIN1;
         end

         ST_FIN1: begin
            prod_in  = IDX_W'(cur_row_ff) * IDX_W'(geom.cols);
            state_in = ST_FIN2;
         end

         ST_FIN2: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // After reset the whole buffer is filled with blank cells before any item.
         state_ff      <= ST_FILL;
         dst_ff        <= '0;
         fill_end_ff   <= MAX_LIM;
         fill_word_ff  <= RESET_CELL;
         ret_ff        <= RET_IDLE;
         pend_ff       <= 1'b0;
         print_pend_ff <= 1'b0;
         cur_col_ff    <= 8'd0;
         cur_row_ff    <= 6'd0;
         color_ff      <= RESET_COLOR;
      end else begin
         state_ff      <= state_in;
         dst_ff        <= dst_in;
         fill_end_ff   <= fill_end_in;
         fill_word_ff  <= fill_word_in;
         ret_ff        <= ret_in;
         pend_ff       <= pend_in;
         print_pend_ff <= print_pend_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         color_ff      <= color_in;
      end
      ch_ff      <= ch_in;
      attr_ff    <= attr_in;
      cidx_ff    <= cidx_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      prod_ff    <= prod_in;
      wx_ff      <= wx_in;
      wr_pend_ff <= wr_pend_in;
      wword_ff   <= wword_in;
      src_ff     <= src_in;
      pdst_ff    <= pdst_in;
      value_ff   <= value_in;
   end

endmodule

`default_nettype wire

>>> hdl/text_console_writer.sv
// Text console writer top level: geometry registers, command sequencer, cell RAM
// and the result register. Depends on tcw_pkg, tcw_geom, tcw_ctrl and tcw_ram.
//
// Usage: an item on the req_ channel carries one command (print at the cursor,
// print at a position, set the cursor, clear, read a cell). Each accepted item
// gives exactly one result on the rsp_ channel: the cursor cell number after the
// command and, for a read, the cell contents.
// One item is worked on at a time; the sequencer walks the cell RAM, which has one
// write and one registered read port. A clear fills every cell of the screen, and
// every cursor placement that scrolls copies the kept lines up and then fills the
// freed lines, the copy reading one cell while it writes the one before. req_stall
// falls at the edge where rsp_valid rises. A configuration write keeps req_stall
// high from its own cycle until the geometry is recomputed, and longer for each
// line dropped while the line count is fitted. After reset, req_stall stays high
// while every cell is filled with a blank in the default colour. A result waits
// in the output register while rsp_stall is high; the next item is still accepted
// and worked on, and it waits for the register only at its very end.
`default_nettype none

module text_console_writer #(
   parameter int MAX_CELLS = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcw_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tcw_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_index,
   input  wire logic [7:0]       csr_wdata
);

   import tcw_pkg::*;

   localparam int AW = $clog2(MAX_CELLS);

   geom_type    geom;
   rsp_type     rsp_next;
   logic        done;
   logic        out_free;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0] mem_wdata;
   logic        mem_re;
   logic [AW-1:0] mem_raddr;
   logic [15:0] mem_rdata;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   tcw_geom #(
      .MAX_CELLS (MAX_CELLS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   tcw_ctrl #(
      .MAX_CELLS (MAX_CELLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .geom      (geom),
      .out_free  (out_free),
      .done      (done),
      .rsp_next  (rsp_next),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The register is free when empty or when its item leaves at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer: directed table, then random command mix.
// Results come from the directed table or a local model of the screen; depends on tcw_pkg and the RTL.
module tb;
   import tcw_pkg::*;

   localparam int CELL_COUNT = 4096;
   localparam int SETTLE_CYCLES = 24;
   localparam int LIMIT_NS = 200_000_000;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam logic [7:0] CHR_HIGH = 8'h80;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } vector_row;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_type        req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_type        rsp_data;
   logic           csr_we = 1'b0;
   logic [0:0]     csr_index = CSR_COLUMNS;
   logic [7:0]     csr_wdata = '0;

   // Local copy of the screen, cursor, colour and geometry registers.
   logic [15:0]    cell_image [0:CELL_COUNT-1];
   int unsigned    cur_x;
   int unsigned    cur_y;
   logic [7:0]     paint_color;
   logic [7:0]     width_reg;
   logic [5:0]     height_reg;

   rsp_type        awaited_rsp[$];
   rsp_type        oldest_rsp;
   vector_row      directed_rows[$];
   int             mismatches = 0;
   bit             steady = 1'b0;

   text_console_writer #(.MAX_CELLS(CELL_COUNT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned geom_cols();
      int unsigned c;
      c = (width_reg == 0) ? 1 : width_reg;
      if (c > CELL_COUNT) c = CELL_COUNT;
      return c;
   endfunction

   function automatic int unsigned geom_lines();
      int unsigned c;
      int unsigned l;
      c = geom_cols();
      l = (height_reg == 0) ? 1 : height_reg;
      if (c * l > CELL_COUNT) l = CELL_COUNT / c;
      return l;
   endfunction

   // A stale cursor may point past the buffer after a geometry change; such writes are dropped.
   function automatic void store_cell(int unsigned x, int unsigned y, logic [7:0] ch,
                                      logic [7:0] attr);
      int unsigned at;
      at = y * geom_cols() + x;
      if (at < CELL_COUNT) cell_image[at] = {attr, ch};
   endfunction

   function automatic void scroll_up(int unsigned k);
      int unsigned c;
      int unsigned l;
      int unsigned keep;
      c = geom_cols();
      l = geom_lines();
      keep = (k < l) ? (l - k) * c : 0;
      for (int unsigned i = 0; i < keep; i++) cell_image[i] = cell_image[i + k * c];
      for (int unsigned i = keep; i < l * c; i++) cell_image[i] = {paint_color, CHR_BLANK};
   endfunction

   // The column wraps once only; a row overrun scrolls once, by one line per row of overrun.
   function automatic void settle_cursor(int unsigned x, int unsigned y);
      int unsigned l;
      l = geom_lines();
      if (x >= geom_cols()) begin
         x = 0;
         y++;
      end
      if (y >= l) begin
         scroll_up(y - l + 1);
         y = l - 1;
      end
      cur_x = x;
      cur_y = y;
   endfunction

   function automatic void print_char(logic [7:0] ch, logic [7:0] attr);
      int unsigned x;
      int unsigned y;
      x = cur_x;
      y = cur_y;
      if (attr == 0) attr = paint_color;
      if (ch == CHR_NL) begin
         x = 0;
         y++;
      end else if (ch == CHR_CR) begin
         x = 0;
      end else if (ch == CHR_TAB) begin
         x = (x + TAB_STEP) & ~(TAB_STEP - 1);
      end else if (ch == CHR_BS) begin
         if (x != 0) x--;
         store_cell(x, y, CHR_BLANK, attr);
      end else if (ch >= CHR_BLANK && ch < CHR_HIGH) begin
         store_cell(x, y, ch, attr);
         x++;
      end
      settle_cursor(x, y);
   endfunction

   function automatic rsp_type console_step(req_type it);
      rsp_type     r;
      logic [7:0]  attr;
      int unsigned n;
      r.cell_value = '0;
      case (it.command)
         CMD_PRINT: print_char(it.character, it.attribute);
         CMD_PRINT_AT: begin
            settle_cursor(it.col, it.row);
            print_char(it.character, it.attribute);
         end
         CMD_SET_CURSOR: settle_cursor(it.col, it.row);
         CMD_CLEAR: begin
            attr = (it.attribute == 0) ? paint_color : it.attribute;
            paint_color = attr;
            n = geom_cols() * geom_lines();
            for (int unsigned i = 0; i < n; i++) cell_image[i] = {attr, CHR_BLANK};
            settle_cursor(0, 0);
         end
         CMD_READ: r.cell_value = cell_image[it.cell_index];
         default: ;
      endcase
      r.cursor_offset = 12'(cur_y * geom_cols() + cur_x);
      return r;
   endfunction

   function automatic req_type random_item();
      req_type     it;
      int unsigned c;
      int unsigned l;
      int unsigned area;
      int unsigned top;
      int unsigned pick;
      c = geom_cols();
      l = geom_lines();
      area = c * l;
      top = (area + c > CELL_COUNT - 1) ? CELL_COUNT - 1 : area + c;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         it.character = 8'($urandom_range(32, 127));
      end else if (pick < 72) begin
         case ($urandom_range(0, 3))
            0: it.character = CHR_NL;
            1: it.character = CHR_CR;
            2: it.character = CHR_TAB;
            default: it.character = CHR_BS;
         endcase
      end else begin
         it.character = 8'($urandom_range(0, 255));
      end
      it.attribute = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(0, 255));
      it.col = $urandom_range(0, 1) ? 8'($urandom_range(0, c)) : 8'($urandom_range(0, 255));
      // Far rows are kept to the tiniest screens.
      if (area <= 16 && $urandom_range(0, 99) < 15) it.row = 8'($urandom_range(0, 255));
      else it.row = 8'($urandom_range(0, l + 1));
      it.cell_index = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, top))
                                                  : 12'($urandom_range(0, CELL_COUNT - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) it.command = CMD_PRINT;
      else if (pick < 60) it.command = CMD_PRINT_AT;
      else if (pick < 75) it.command = CMD_SET_CURSOR;
      else if (pick < 80) it.command = CMD_CLEAR;
      else if (pick < 97) it.command = CMD_READ;
      else it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      return it;
   endfunction

   function automatic void add_row(logic [2:0] cmd, logic [7:0] ch, logic [7:0] attr,
                                   logic [7:0] col, logic [7:0] row, logic [11:0] idx,
                                   bit typed, logic [11:0] offset, logic [15:0] value);
      vector_row v;
      v.item = '{command: cmd, character: ch, attribute: attr, col: col, row: row,
                 cell_index: idx};
      v.typed = typed;
      v.want = '{cursor_offset: offset, cell_value: value};
      directed_rows.push_back(v);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatches < 40) $display("mismatch on %s: got %h, want %h at %0t", what, got, want,
                                    $time);
      mismatches++;
   endtask

   task automatic send_item(input req_type it);
      if (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue(input req_type it);
      send_item(it);
      awaited_rsp.push_back(console_step(it));
   endtask

   task automatic wait_idle();
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [7:0] cols, input logic [5:0] rows);
      csr_we <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_LINES;
      csr_wdata <= {2'b00, rows};
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg = cols;
      height_reg = rows;
   endtask

   // Each phase opens with a print, so a cursor left stale by the new geometry is exercised,
   // and closes on the last row, which leaves a stale cursor for the next phase.
   task automatic run_phase(input logic [7:0] cols, input logic [5:0] rows, input int count);
      req_type it;
      wait_idle();
      write_geometry(cols, rows);
      it = random_item();
      it.command = CMD_PRINT;
      it.character = 8'($urandom_range(32, 126));
      issue(it);
      repeat (count - 2) issue(random_item());
      it = random_item();
      it.command = CMD_SET_CURSOR;
      it.col = '0;
      it.row = 8'(geom_lines() - 1);
      issue(it);
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected result", {4'h0, rsp_data.cursor_offset}, '0);
         end else begin
            oldest_rsp = awaited_rsp.pop_front();
            if (rsp_data.cursor_offset !== oldest_rsp.cursor_offset)
               report_mismatch("cursor_offset", {4'h0, rsp_data.cursor_offset},
                               {4'h0, oldest_rsp.cursor_offset});
            if (rsp_data.cell_value !== oldest_rsp.cell_value)
               report_mismatch("cell_value", rsp_data.cell_value, oldest_rsp.cell_value);
         end
      end
   end

   initial begin
      rsp_type got;
      for (int i = 0; i < CELL_COUNT; i++) cell_image[i] = RESET_CELL;
      cur_x = 0;
      cur_y = 0;
      paint_color = RESET_COLOR;
      width_reg = RESET_COLUMNS;
      height_reg = RESET_LINES;

      // Default 80 by 25 screen straight out of reset.
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd0, RESET_CELL);
      add_row(CMD_PRINT, 8'h41, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd1, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd1, 16'h0741);
      add_row(CMD_PRINT, 8'h7F, 8'hFF, 8'h00, 8'h00, 12'd0, 1, 12'd2, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd1, 1, 12'd2, 16'hFF7F);
      add_row(CMD_PRINT, CHR_HIGH, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd2, 16'h0000);
      add_row(CMD_PRINT, 8'hFF, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd2, 16'h0000);
      add_row(CMD_PRINT, 8'h1F, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd2, 16'h0000);
      add_row(CMD_PRINT, CHR_TAB, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd8, 16'h0000);
      add_row(CMD_PRINT, CHR_BS, 8'h1E, 8'h00, 8'h00, 12'd0, 1, 12'd7, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd7, 1, 12'd7, 16'h1E20);
      add_row(CMD_PRINT, CHR_CR, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd0, 16'h0000);
      // Backspace in the first column blanks that cell and stays put.
      add_row(CMD_PRINT, CHR_BS, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd0, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd0, 16'h0720);
      add_row(CMD_PRINT, CHR_NL, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd80, 16'h0000);
      add_row(CMD_SET_CURSOR, 8'h00, 8'h00, 8'd79, 8'd24, 12'd0, 1, 12'd1999, 16'h0000);
      // Printing in the last cell wraps and scrolls the screen by one line.
      add_row(CMD_PRINT, 8'h5A, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd1920, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd1919, 1, 12'd1920, 16'h075A);
      add_row(CMD_PRINT_AT, 8'h71, 8'h80, 8'hFF, 8'd26, 12'd0, 0, 12'd0, 16'h0000);
      add_row(CMD_CLEAR, 8'h00, 8'h4F, 8'h00, 8'h00, 12'd0, 1, 12'd0, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd4095, 1, 12'd0, RESET_CELL);
      add_row(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 1, 12'd0, 16'h0000);
      add_row(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 12'd5, 1, 12'd0, 16'h4F20);
      add_row(CMD_SPARE_LO, 8'h41, 8'h11, 8'd3, 8'd3, 12'd3, 1, 12'd0, 16'h0000);
      add_row(CMD_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 1, 12'd0, 16'h0000);
      add_row(CMD_PRINT, 8'h61, 8'h00, 8'h00, 8'h00, 12'd0, 0, 12'd0, 16'h0000);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item);
         got = console_step(directed_rows[i].item);
         awaited_rsp.push_back(directed_rows[i].typed ? directed_rows[i].want : got);
      end
      req_valid <= 1'b0;

      run_phase(8'd1, 6'd1, 150);
      run_phase(8'd0, 6'd0, 60);
      run_phase(8'd8, 6'd4, 300);
      run_phase(8'd1, 6'd32, 150);
      run_phase(8'd255, 6'd63, 50);
      steady <= 1'b1;
      run_phase(8'd16, 6'd8, 300);
      steady <= 1'b0;
      run_phase(8'd3, 6'd5, 250);
      run_phase(8'd128, 6'd32, 50);
      run_phase(8'd63, 6'd0, 150);
      run_phase(8'd40, 6'd12, 250);
      run_phase(8'd80, 6'd25, 80);
      run_phase(8'd7, 6'd63, 150);

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
